// File: design/bbwf_pkg.sv
// ----------------------------------------------------------------------------
// Beam-break window filter package
// Shared sizes, register indexes, controller states and the command struct.
// ----------------------------------------------------------------------------
package bbwf_pkg;

  // Window length in samples and number of sensors qualified in parallel.
  localparam int KERNEL  = 16;
  localparam int SENSORS = 3;

  // Derived widths.
  localparam int POS_W   = (KERNEL > 1) ? $clog2(KERNEL) : 1;
  localparam int CNT_W   = $clog2(KERNEL + 1);
  localparam int THR_W   = 5;
  localparam int CMP_W   = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int HOLD_W  = 8;
  localparam int LIGHT_W = 16;
  localparam int RAW_W   = 3;
  localparam int RAW_EXT_W = 8;

  // Stream and configuration port widths.
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Which timers drive the goal light pins.
  localparam int HUM_IDX = 1 % SENSORS;
  localparam int ROB_IDX = 2 % SENSORS;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0]   THR_CENTRE_RST = THR_W'(10);
  localparam logic [THR_W-1:0]   THR_GOAL_RST   = THR_W'(5);
  localparam logic               BLOCKED_RST    = 1'b1;
  localparam logic [HOLD_W-1:0]  HOLD_RST       = HOLD_W'(250);
  localparam logic [LIGHT_W-1:0] LIGHT_RST      = LIGHT_W'(1000);
  localparam logic [LIGHT_W-1:0] STARTUP_RST    = LIGHT_W'(1000);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR_CENTRE = 3'd0,
    REG_THR_HUMAN  = 3'd1,
    REG_THR_ROBOT  = 3'd2,
    REG_BLOCKED    = 3'd3,
    REG_HOLD       = 3'd4,
    REG_LIGHT      = 3'd5,
    REG_STARTUP    = 3'd6
  } reg_idx_e;

  // Input item kinds.
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_FILTER = 1'b1
  } req_type_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_COUNT  = 2'd1,
    ST_UPDATE = 2'd2
  } ctrl_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic latch_in;
    logic count;
    logic update;
  } ctrl_cmd_t;

endpackage

// File: design/beam_break_window_filter.sv
// Steps: the controller latches an item, counts its window, then loads the
// result register in its update step. A new item is taken only once the
// controller is back in idle; a result left waiting holds the next item in
// its update step.
// Reset: asynchronous, active low; windows, timers and flags clear, blanking
// loads 1000 ticks, both light pins go high, registers take their defaults.
// ----------------------------------------------------------------------------
// Beam-break window filter
// Qualifies three beam-break sensors over a sliding window of samples with
// hold time, startup blanking and goal-light timers.
// ----------------------------------------------------------------------------
module beam_break_window_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bbwf_pkg::S_DATA_W-1:0]   s_axis_tdata,  // [2:0] raw_bits
  input  logic                            s_axis_tuser,  // [0] req_type
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] filtered_centre, [1] filtered_human, [2] filtered_robot,
  // [3] light_human_pin, [4] light_robot_pin
  output logic [bbwf_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [bbwf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bbwf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bbwf_pkg::*;

  ctrl_cmd_t cmd;

  // Sequencer and handshakes.
  bbwf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Filter state and arithmetic.
  bbwf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_type_i (s_axis_tuser),
    .raw_bits_i (s_axis_tdata[RAW_W-1:0]),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (m_axis_tdata)
  );

endmodule

// File: design/bbwf_ctrl.sv
// ----------------------------------------------------------------------------
// Beam-break window filter controller
// Sequences latch, count and update steps and owns the handshakes.
// ----------------------------------------------------------------------------
module bbwf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bbwf_pkg::ctrl_cmd_t cmd_o
);
  import bbwf_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_ready;

  // The input side opens whenever the controller is idle; a waiting result
  // is held in the datapath's result register.
  assign in_ready    = (state_q == ST_IDLE);
  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

  // State and result-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands. The update step waits until the result
  // register is free or being emptied in this cycle.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd_o.count = 1'b1;
        state_d     = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/bbwf_datapath.sv
// ----------------------------------------------------------------------------
// Beam-break window filter datapath
// Sample windows, blocked-sample counts, hold and light timers, config regs.
// ----------------------------------------------------------------------------
module bbwf_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bbwf_pkg::ctrl_cmd_t                cmd_i,
  input  logic                               req_type_i,
  input  logic [bbwf_pkg::RAW_W-1:0]         raw_bits_i,
  input  logic                               cfg_we_i,
  input  logic [bbwf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bbwf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic [bbwf_pkg::M_DATA_W-1:0]      result_o
);
  import bbwf_pkg::*;

  // Configuration registers.
  logic [THR_W-1:0]   thr_centre_q, thr_human_q, thr_robot_q;
  logic               blocked_q;
  logic [HOLD_W-1:0]  hold_ticks_q;
  logic [LIGHT_W-1:0] light_ticks_q;

  // Latched item.
  logic               req_q;
  logic [RAW_W-1:0]   raw_q;

  // Filter state.
  logic [KERNEL-1:0]  win_q   [SENSORS];
  logic [KERNEL-1:0]  win_d   [SENSORS];
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [HOLD_W-1:0]  hold_q  [SENSORS];
  logic [HOLD_W-1:0]  hold_d  [SENSORS];
  logic [LIGHT_W-1:0] timer_q [SENSORS];
  logic [LIGHT_W-1:0] timer_d [SENSORS];
  logic [SENSORS-1:0] flag_q, flag_d;
  logic [LIGHT_W-1:0] blank_q, blank_d;
  logic [1:0]         pins_q, pins_d;
  logic [CNT_W-1:0]   cnt_q   [SENSORS];
  logic [CNT_W-1:0]   cnt_d   [SENSORS];
  logic [M_DATA_W-1:0] res_q;

  logic [RAW_EXT_W-1:0] raw_ext;
  logic [THR_W-1:0]     thr     [SENSORS];
  logic [2:0]           out_flags;

  assign raw_ext = {{(RAW_EXT_W-RAW_W){1'b0}}, raw_q};

  // Sensors past the robot goal share its threshold.
  always_comb begin
    for (int s = 0; s < SENSORS; s++) begin
      if (s == 0) begin
        thr[s] = thr_centre_q;
      end else if (s == 1) begin
        thr[s] = thr_human_q;
      end else begin
        thr[s] = thr_robot_q;
      end
    end
  end

  // Configuration registers; the user writes only while idle, unenforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_centre_q  <= THR_CENTRE_RST;
      thr_human_q   <= THR_GOAL_RST;
      thr_robot_q   <= THR_GOAL_RST;
      blocked_q     <= BLOCKED_RST;
      hold_ticks_q  <= HOLD_RST;
      light_ticks_q <= LIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THR_CENTRE: thr_centre_q  <= cfg_data_i[THR_W-1:0];
        REG_THR_HUMAN:  thr_human_q   <= cfg_data_i[THR_W-1:0];
        REG_THR_ROBOT:  thr_robot_q   <= cfg_data_i[THR_W-1:0];
        REG_BLOCKED:    blocked_q     <= cfg_data_i[0];
        REG_HOLD:       hold_ticks_q  <= cfg_data_i[HOLD_W-1:0];
        REG_LIGHT:      light_ticks_q <= cfg_data_i[LIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Item latch and per-sensor counts of blocked samples.
  always_comb begin
    for (int s = 0; s < SENSORS; s++) begin
      cnt_d[s] = '0;
      for (int k = 0; k < KERNEL; k++) begin
        cnt_d[s] = cnt_d[s] + CNT_W'(win_q[s][k] == blocked_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      req_q <= req_type_i;
      raw_q <= raw_bits_i;
    end
    if (cmd_i.count) begin
      cnt_q <= cnt_d;
    end
  end

  // Next filter state: sample store, blanking, or per-sensor qualification.
  always_comb begin
    win_d   = win_q;
    pos_d   = pos_q;
    hold_d  = hold_q;
    timer_d = timer_q;
    flag_d  = flag_q;
    blank_d = blank_q;
    pins_d  = pins_q;
    if (cmd_i.update) begin
      if (req_q == REQ_SAMPLE) begin
        for (int s = 0; s < SENSORS; s++) begin
          win_d[s][pos_q] = (s < RAW_W) ? raw_ext[s] : 1'b0;
        end
        pos_d = (pos_q == POS_W'(KERNEL - 1)) ? '0 : pos_q + POS_W'(1);
      end else if (blank_q != '0) begin
        blank_d = blank_q - LIGHT_W'(1);
      end else begin
        for (int s = 0; s < SENSORS; s++) begin
          if (CMP_W'(cnt_q[s]) >= CMP_W'(thr[s])) begin
            timer_d[s] = light_ticks_q;
            flag_d[s]  = 1'b1;
            hold_d[s]  = hold_ticks_q;
          end else begin
            if (hold_q[s] != '0) begin
              flag_d[s] = 1'b1;
              hold_d[s] = hold_q[s] - HOLD_W'(1);
            end else begin
              flag_d[s] = 1'b0;
            end
            if (timer_q[s] != '0) begin
              timer_d[s] = timer_q[s] - LIGHT_W'(1);
            end
          end
        end
        // Human light is active low, robot light active high.
        if (SENSORS > 1) begin
          pins_d[0] = (timer_d[HUM_IDX] == '0);
        end
        if (SENSORS > 2) begin
          pins_d[1] = (timer_d[ROB_IDX] != '0);
        end
      end
    end
    // Writing the startup count restarts blanking.
    if (cfg_we_i && (cfg_idx_i == REG_STARTUP)) begin
      blank_d = cfg_data_i[LIGHT_W-1:0];
    end
  end

  // Filter state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SENSORS; s++) begin
        win_q[s]   <= '0;
        hold_q[s]  <= '0;
        timer_q[s] <= '0;
      end
      pos_q   <= '0;
      flag_q  <= '0;
      blank_q <= STARTUP_RST;
      pins_q  <= 2'b11;
    end else begin
      win_q   <= win_d;
      pos_q   <= pos_d;
      hold_q  <= hold_d;
      timer_q <= timer_d;
      flag_q  <= flag_d;
      blank_q <= blank_d;
      pins_q  <= pins_d;
    end
  end

  // Flags of the updated state; absent sensors read as clear.
  always_comb begin
    for (int s = 0; s < 3; s++) begin
      out_flags[s] = (s < SENSORS) ? flag_d[s % SENSORS] : 1'b0;
    end
  end

  // Result register, loaded at the update step and held until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (cmd_i.update) begin
      res_q <= {{(M_DATA_W-5){1'b0}}, pins_d[1], pins_d[0], out_flags};
    end
  end

  assign result_o = res_q;

endmodule

// File: design/bbwf_checker.sv
// ----------------------------------------------------------------------------
// Beam-break window filter checker
// Port-level properties on transfer timing, bound to the top level.
// ----------------------------------------------------------------------------
module bbwf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [bbwf_pkg::M_DATA_W-1:0]   m_axis_tdata
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The block is busy right after taking an item.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input accepted during processing");

  // Every input transfer is followed by a valid result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##3 m_axis_tvalid)
    else $error("result missing after input transfer");

  // A new result only appears after an input transfer.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(in_xfer, 3))
    else $error("result without input transfer");

endmodule

bind beam_break_window_filter bbwf_checker u_bbwf_checker (.*);

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Beam-break window filter testbench
// Sends sample and filter ticks over the input stream. A cycle-free model of
// the sensor windows, hold counters, light timers and startup blanking
// computes the flags and light pins expected from each accepted tick. Each
// result transfer is checked against the oldest pending expectation. Both
// stream sides idle at random. One receiver stall is long enough to fill the
// block.
// ----------------------------------------------------------------------------
module tb_top;
  import bbwf_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int MAX_GAP    = 17;
  localparam int REPORT_MAX = 10;
  localparam int LONG_STALL = 60;
  localparam int PHASES     = 12;
  localparam int PHASE_ITEMS = 110;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Result fields, lowest bit first from the bottom of the struct.
  typedef struct packed {
    logic light_robot;
    logic light_human;
    logic flt_robot;
    logic flt_human;
    logic flt_centre;
  } filter_out_t;

  localparam int OUT_W = $bits(filter_out_t);

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Filter model: configuration copy and sensor state.
  logic [THR_W-1:0]   thr_cfg [SENSORS];
  logic               blocked_cfg;
  logic [HOLD_W-1:0]  hold_cfg;
  logic [LIGHT_W-1:0] light_cfg;
  logic [LIGHT_W-1:0] startup_cfg;
  logic [KERNEL-1:0]  window_q [SENSORS];
  logic [POS_W-1:0]   wr_pos_q;
  logic [HOLD_W-1:0]  hold_q [SENSORS];
  logic [LIGHT_W-1:0] light_q [SENSORS];
  logic               qual_q [SENSORS];
  logic [LIGHT_W-1:0] blank_q;
  logic               pin_human_q;
  logic               pin_robot_q;

  filter_out_t pending_flags_q [$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          src_idle_en;
  bit          snk_idle_en;
  int          sink_stall_req = 0;

  always #1 clk_i = ~clk_i;

  beam_break_window_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [2:0] raw_bits
    .s_axis_tuser  (s_axis_tuser),   // [0] req_type
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // [0] filtered_centre, [1] filtered_human, [2] filtered_robot,
    // [3] light_human_pin, [4] light_robot_pin
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Model state after reset.
  function automatic void filter_model_reset();
    thr_cfg[0]  = THR_CENTRE_RST;
    for (int s = 1; s < SENSORS; s++) thr_cfg[s] = THR_GOAL_RST;
    blocked_cfg = BLOCKED_RST;
    hold_cfg    = HOLD_RST;
    light_cfg   = LIGHT_RST;
    startup_cfg = STARTUP_RST;
    for (int s = 0; s < SENSORS; s++) begin
      window_q[s] = '0;
      hold_q[s]   = '0;
      light_q[s]  = '0;
      qual_q[s]   = 1'b0;
    end
    wr_pos_q    = '0;
    blank_q     = STARTUP_RST;
    pin_human_q = 1'b1;
    pin_robot_q = 1'b1;
  endfunction

  // Register write as seen by the model; only the register's own bits count.
  function automatic void filter_model_config(logic [CFG_IDX_W-1:0] idx,
                                              logic [CFG_DATA_W-1:0] word);
    case (idx)
      REG_THR_CENTRE: thr_cfg[0] = word[THR_W-1:0];
      REG_THR_HUMAN:  thr_cfg[1] = word[THR_W-1:0];
      REG_THR_ROBOT: begin
        for (int s = 2; s < SENSORS; s++) thr_cfg[s] = word[THR_W-1:0];
      end
      REG_BLOCKED:    blocked_cfg = word[0];
      REG_HOLD:       hold_cfg = word[HOLD_W-1:0];
      REG_LIGHT:      light_cfg = word[LIGHT_W-1:0];
      REG_STARTUP: begin
        // Writing the startup count also restarts the blanking.
        startup_cfg = word[LIGHT_W-1:0];
        blank_q     = word[LIGHT_W-1:0];
      end
      default: ;
    endcase
  endfunction

  // Advances the model by one tick and returns the flags and pins it reports.
  function automatic filter_out_t filter_model_step(req_type_e req,
                                                    logic [RAW_W-1:0] raw);
    int          count;
    filter_out_t res;
    if (req == REQ_SAMPLE) begin
      // Overwrite the oldest sample of every window.
      for (int s = 0; s < SENSORS; s++) begin
        window_q[s][wr_pos_q] = (s < RAW_W) ? raw[s] : 1'b0;
      end
      wr_pos_q = (wr_pos_q == POS_W'(KERNEL - 1)) ? '0 : wr_pos_q + 1'b1;
    end else if (blank_q != '0) begin
      blank_q = blank_q - 1'b1;
    end else begin
      for (int s = 0; s < SENSORS; s++) begin
        count = 0;
        for (int k = 0; k < KERNEL; k++) begin
          if (window_q[s][k] == blocked_cfg) count++;
        end
        if (count >= int'(thr_cfg[s])) begin
          light_q[s] = light_cfg;
          qual_q[s]  = 1'b1;
          hold_q[s]  = hold_cfg;
        end else begin
          // Below threshold: hold keeps the flag up while it runs down.
          if (hold_q[s] != '0) begin
            qual_q[s] = 1'b1;
            hold_q[s] = hold_q[s] - 1'b1;
          end else begin
            qual_q[s] = 1'b0;
          end
          if (light_q[s] != '0) light_q[s] = light_q[s] - 1'b1;
        end
      end
      pin_human_q = (light_q[HUM_IDX] == '0);
      pin_robot_q = (light_q[ROB_IDX] != '0);
    end
    res.flt_centre  = qual_q[0];
    res.flt_human   = qual_q[1];
    res.flt_robot   = qual_q[2];
    res.light_human = pin_human_q;
    res.light_robot = pin_robot_q;
    return res;
  endfunction

  function automatic void flag_mismatch(string field, logic [M_DATA_W-1:0] want,
                                        logic [M_DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  // Compares one result transfer with the oldest pending expectation.
  function automatic void check_result(logic [M_DATA_W-1:0] word);
    filter_out_t want;
    filter_out_t got;
    string       names [OUT_W];
    names = '{"filtered_centre", "filtered_human", "filtered_robot",
              "light_human_pin", "light_robot_pin"};
    if (pending_flags_q.size() == 0) begin
      flag_mismatch("unexpected result", '0, word);
    end else begin
      want = pending_flags_q.pop_front();
      got  = word[OUT_W-1:0];
      for (int b = 0; b < OUT_W; b++) begin
        if (got[b] !== want[b]) begin
          flag_mismatch(names[b], M_DATA_W'(want[b]), M_DATA_W'(got[b]));
        end
      end
      if (word[M_DATA_W-1:OUT_W] !== '0) begin
        flag_mismatch("tdata padding", '0, M_DATA_W'(word[M_DATA_W-1:OUT_W]));
      end
    end
  endfunction

  // Result check at every result transfer.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  // Watchdog: a long run of cycles without any transfer or write ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver: random gaps per transfer, plus one long stall on request.
  initial begin : result_sink
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = snk_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (sink_stall_req > 0) begin
        gap = sink_stall_req;
        sink_stall_req = 0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // Offers one tick and records its expected result once it is accepted.
  task automatic send_item(input req_type_e req, input logic [RAW_W-1:0] raw);
    int gap;
    gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  <= req;
    s_axis_tdata  <= S_DATA_W'(raw);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_flags_q.push_back(filter_model_step(req, raw));
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every pending result has been taken.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (pending_flags_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] word);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= word;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    filter_model_config(idx, word);
  endtask

  // Blanking after reset, its reload by a write, and all-zero windows that
  // count as blocked when the blocked level is low.
  task automatic test_startup_blanking();
    send_item(REQ_FILTER, 3'b101);
    send_item(REQ_SAMPLE, 3'b010);
    wait_results_done();
    write_reg(REG_STARTUP, 16'd1);
    write_reg(REG_BLOCKED, 16'd0);
    send_item(REQ_FILTER, 3'b000);
    send_item(REQ_FILTER, 3'b111);
    send_item(REQ_SAMPLE, 3'b111);
    wait_results_done();
  endtask

  // Threshold of zero, at the window size and above it; zero hold and light.
  task automatic test_threshold_extremes();
    write_reg(REG_THR_CENTRE, 16'd0);
    write_reg(REG_THR_HUMAN, 16'd16);
    write_reg(REG_THR_ROBOT, 16'd31);
    write_reg(REG_BLOCKED, 16'd1);
    write_reg(REG_HOLD, 16'd0);
    write_reg(REG_LIGHT, 16'd0);
    for (int v = 0; v < 8; v++) send_item(REQ_SAMPLE, RAW_W'(v));
    send_item(REQ_FILTER, 3'b000);
    wait_results_done();
    write_reg(REG_THR_HUMAN, 16'd5);
    send_item(REQ_FILTER, 3'b111);
    send_item(REQ_SAMPLE, 3'b000);
    wait_results_done();
  endtask

  // Largest reload values, longest blanking, and a write to no register.
  task automatic test_reload_extremes();
    write_reg(REG_HOLD, 16'd255);
    write_reg(REG_LIGHT, 16'hffff);
    write_reg(REG_STARTUP, 16'hffff);
    send_item(REQ_FILTER, 3'b011);
    wait_results_done();
    write_reg(REG_STARTUP, 16'd0);
    write_reg(REG_UNUSED, 16'hffff);
    send_item(REQ_FILTER, 3'b110);
    send_item(REQ_SAMPLE, RAW_W'($urandom));
    wait_results_done();
  endtask

  function automatic logic [THR_W-1:0] draw_threshold();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return THR_W'(KERNEL);
      2:       return THR_W'($urandom_range(KERNEL + 1, 31));
      default: return THR_W'($urandom_range(1, KERNEL));
    endcase
  endfunction

  // New settings for a phase; short hold and light times dominate so that
  // flags and lights get to drop again. Unused upper data bits carry junk.
  task automatic randomize_config();
    write_reg(REG_THR_CENTRE, {11'($urandom), draw_threshold()});
    write_reg(REG_THR_HUMAN, {11'($urandom), draw_threshold()});
    write_reg(REG_THR_ROBOT, {11'($urandom), draw_threshold()});
    write_reg(REG_BLOCKED, {15'($urandom), 1'($urandom)});
    write_reg(REG_HOLD, {8'($urandom), ($urandom_range(0, 3) == 0) ?
                         8'($urandom) : 8'($urandom_range(0, 8))});
    write_reg(REG_LIGHT, ($urandom_range(0, 4) == 0) ?
                         16'($urandom) : 16'($urandom_range(0, 12)));
    write_reg(REG_STARTUP, ($urandom_range(0, 4) == 0) ?
                           16'($urandom_range(0, 40)) : 16'($urandom_range(0, 3)));
  endtask

  // One scene: each sensor sees the beam blocked with its own likelihood,
  // with sample and filter ticks mixed and a little noise.
  task automatic run_scene(output int sent);
    int               prob [RAW_W];
    logic [RAW_W-1:0] raw;
    req_type_e        req;
    sent = $urandom_range(8, 40);
    for (int s = 0; s < RAW_W; s++) prob[s] = 25 * $urandom_range(0, 4);
    repeat (sent) begin
      if ($urandom_range(0, 9) == 0) begin
        raw = RAW_W'($urandom);
      end else begin
        for (int s = 0; s < RAW_W; s++) begin
          raw[s] = ($urandom_range(0, 99) < prob[s]) ? blocked_cfg : !blocked_cfg;
        end
      end
      req = ($urandom_range(0, 2) == 0) ? REQ_FILTER : REQ_SAMPLE;
      send_item(req, raw);
    end
  endtask

  task automatic test_random_scenes();
    int sent;
    int total;
    for (int p = 0; p < PHASES; p++) begin
      randomize_config();
      case ($urandom_range(0, 3))
        0: begin src_idle_en = 1'b0; snk_idle_en = 1'b0; end
        1: begin src_idle_en = 1'b1; snk_idle_en = 1'b0; end
        2: begin src_idle_en = 1'b0; snk_idle_en = 1'b1; end
        default: begin src_idle_en = 1'b1; snk_idle_en = 1'b1; end
      endcase
      total = 0;
      while (total < PHASE_ITEMS) begin
        run_scene(sent);
        total += sent;
      end
      wait_results_done();
    end
  endtask

  // The receiver stalls for a long stretch while ticks keep coming, so the
  // block fills and holds off its input.
  task automatic test_backpressure();
    src_idle_en    = 1'b0;
    snk_idle_en    = 1'b0;
    sink_stall_req = LONG_STALL;
    repeat (30) begin
      send_item(($urandom_range(0, 2) == 0) ? REQ_FILTER : REQ_SAMPLE,
                RAW_W'($urandom));
    end
    wait_results_done();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_SAMPLE;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_THR_CENTRE;
    cfg_data_i    = '0;
    src_idle_en   = 1'b1;
    snk_idle_en   = 1'b1;
    filter_model_reset();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_startup_blanking();
    test_threshold_extremes();
    test_reload_extremes();
    test_backpressure();
    test_random_scenes();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_flags_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
